[hw/rtl/sufe_pkg.sv]
// Shared types and codes for the serial upload frame executor.
`default_nettype none

package sufe_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_RESP = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CPU_WRITE = 3'd1,
    EV_GFX_WRITE = 3'd2,
    EV_PTR_READ  = 3'd3,
    EV_KEY       = 3'd4,
    EV_DETACH    = 3'd5,
    EV_CSUM_ERR  = 3'd6,
    EV_BUSY_DROP = 3'd7
  } ev_kind_t;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_CHECK   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [7:0] CMD_DETACH  = 8'd0;
  localparam logic [7:0] CMD_WRITE   = 8'd1;
  localparam logic [7:0] CMD_CPU_PTR = 8'd2;
  localparam logic [7:0] CMD_GFX_PTR = 8'd3;
  localparam logic [7:0] CMD_IND_PTR = 8'd4;
  localparam logic [7:0] CMD_KEY     = 8'd5;

endpackage

`default_nettype wire

[hw/rtl/serial_upload_frame_executor.sv]
// Serial upload frame executor: packet framing, checksum and command execution.
//
// Input channel (in_valid/in_ready) takes one request per cycle: a received
// serial byte, a drain tick, or a pointer read response. Packets are a length
// byte, a checksum byte and the payload; payload byte 0 is the command.
// Result channel (out_valid/out_ready) carries at most one event per request;
// requests that cause no event produce nothing on it.
// An event is registered in the event stage when its request is accepted (the
// packet store read happens then too) and moves on to the output register that
// drives out_valid. Throughput: one request per cycle while out_ready is high;
// the event stage and the output register act as a two-entry queue, so
// in_ready drops only when both hold events and out_ready is low.
// Write data for drain ticks comes from the packet store RAM, read at the
// accept edge of the tick.
// Reset (rst_n low, synchronous) returns framing to awaiting a length byte,
// invalidates the write pointer and empties both event stages. Packet store
// contents are not cleared.
`default_nettype none

module serial_upload_frame_executor
  import sufe_pkg::*;
#(
  parameter int PACKET_STORE_BYTES = 256,
  parameter int CPU_SPACE_BYTES    = 65536,
  parameter int GFX_SPACE_BYTES    = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [15:0] in_read_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [15:0]      out_target_address,
  output logic [7:0]       out_data_byte
);

  localparam int         ADDR_W    = $clog2(PACKET_STORE_BYTES);
  localparam logic [8:0] STORE_LIM = 9'(PACKET_STORE_BYTES);
  localparam logic [7:0] LEN_CAP   = 8'(PACKET_STORE_BYTES - 2);
  localparam logic [16:0] CPU_LIM  = 17'(CPU_SPACE_BYTES);
  localparam logic [16:0] GFX_LIM  = 17'(GFX_SPACE_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  exp_sum_r, exp_sum_nxt;
  logic [7:0]  run_sum_r, run_sum_nxt;
  logic [7:0]  byte_idx_r, byte_idx_nxt;
  logic        ptr_vld_r, ptr_vld_nxt;
  logic        ptr_gfx_r, ptr_gfx_nxt;
  logic [15:0] wr_addr_r, wr_addr_nxt;
  logic        at_end_r, at_end_nxt;
  logic [7:0]  drain_rem_r, drain_rem_nxt;
  logic [7:0]  drain_idx_r, drain_idx_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  head0_r, head0_nxt;
  logic [7:0]  head1_r, head1_nxt;
  logic [7:0]  head2_r, head2_nxt;

  logic        in_acc;
  logic        busy;
  logic [7:0]  sum_add;
  logic [7:0]  idx_inc;
  logic [15:0] cmd_addr;
  logic [16:0] next_addr;
  logic        st_we;
  logic        ram_re;
  logic [7:0]  ram_rdata;

  logic        res_vld;
  ev_kind_t    res_kind;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  logic        res_ram;

  logic        p_vld_r;
  ev_kind_t    p_kind_r;
  logic [15:0] p_addr_r;
  logic [7:0]  p_data_r;
  logic        p_ram_r;
  logic        p_adv;
  logic        out_free;

  logic        out_vld_r;
  ev_kind_t    out_kind_r;
  logic [15:0] out_addr_r;
  logic [7:0]  out_data_r;

  assign out_free = !out_vld_r || out_ready;
  assign p_adv    = p_vld_r && out_free;
  assign in_ready = !p_vld_r || out_free;
  assign in_acc   = in_valid && in_ready;
  assign busy     = (drain_rem_r != 8'd0) || await_r;
  assign sum_add  = run_sum_r + in_rx_byte;
  assign idx_inc  = byte_idx_r + 8'd1;
  assign next_addr = {1'b0, wr_addr_r} + 17'd1;

  sufe_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (byte_idx_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (ram_re),
    .rd_addr (drain_idx_r[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    exp_sum_nxt   = exp_sum_r;
    run_sum_nxt   = run_sum_r;
    byte_idx_nxt  = byte_idx_r;
    ptr_vld_nxt   = ptr_vld_r;
    ptr_gfx_nxt   = ptr_gfx_r;
    wr_addr_nxt   = wr_addr_r;
    at_end_nxt    = at_end_r;
    drain_rem_nxt = drain_rem_r;
    drain_idx_nxt = drain_idx_r;
    await_nxt     = await_r;
    head0_nxt     = head0_r;
    head1_nxt     = head1_r;
    head2_nxt     = head2_r;
    cmd_addr      = 16'd0;
    st_we         = 1'b0;
    ram_re        = 1'b0;
    res_vld       = 1'b0;
    res_kind      = EV_NONE;
    res_addr      = 16'd0;
    res_data      = 8'd0;
    res_ram       = 1'b0;

    if (in_acc) begin
      unique case (in_operation)
        OP_BYTE: begin
          if (busy) begin
            res_vld  = 1'b1;
            res_kind = EV_BUSY_DROP;
          end else if (phase_r == PH_LENGTH) begin
            if (in_rx_byte != 8'd0) begin
              frame_len_nxt = (in_rx_byte > LEN_CAP) ? LEN_CAP : in_rx_byte;
              phase_nxt     = PH_CHECK;
            end
          end else if (phase_r == PH_CHECK) begin
            exp_sum_nxt  = in_rx_byte;
            run_sum_nxt  = 8'd0;
            byte_idx_nxt = 8'd0;
            phase_nxt    = PH_PAYLOAD;
          end else begin
            st_we        = ({1'b0, byte_idx_r} < STORE_LIM);
            run_sum_nxt  = sum_add;
            byte_idx_nxt = idx_inc;
            if (byte_idx_r == 8'd0) begin
              head0_nxt = in_rx_byte;
            end
            if (byte_idx_r == 8'd1) begin
              head1_nxt = in_rx_byte;
            end
            if (byte_idx_r == 8'd2) begin
              head2_nxt = in_rx_byte;
            end
            cmd_addr = {head2_nxt, head1_nxt};
            if (!(idx_inc < frame_len_r)) begin
              phase_nxt = PH_LENGTH;
              if (sum_add != exp_sum_r) begin
                res_vld  = 1'b1;
                res_kind = EV_CSUM_ERR;
              end else begin
                unique case (head0_nxt)
                  CMD_DETACH: begin
                    res_vld  = 1'b1;
                    res_kind = EV_DETACH;
                  end
                  CMD_WRITE: begin
                    if (ptr_vld_r) begin
                      drain_rem_nxt = frame_len_r - 8'd1;
                      drain_idx_nxt = 8'd1;
                    end
                  end
                  CMD_CPU_PTR: begin
                    ptr_vld_nxt = 1'b1;
                    ptr_gfx_nxt = 1'b0;
                    wr_addr_nxt = cmd_addr;
                    at_end_nxt  = ({1'b0, cmd_addr} >= CPU_LIM);
                  end
                  CMD_GFX_PTR: begin
                    if ({1'b0, cmd_addr} >= GFX_LIM) begin
                      ptr_vld_nxt = 1'b0;
                    end else begin
                      ptr_vld_nxt = 1'b1;
                      ptr_gfx_nxt = 1'b1;
                      wr_addr_nxt = cmd_addr;
                      at_end_nxt  = 1'b0;
                    end
                  end
                  CMD_IND_PTR: begin
                    await_nxt = 1'b1;
                    res_vld   = 1'b1;
                    res_kind  = EV_PTR_READ;
                    res_addr  = cmd_addr;
                  end
                  CMD_KEY: begin
                    res_vld  = 1'b1;
                    res_kind = EV_KEY;
                    res_data = head1_nxt;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        OP_TICK: begin
          if (drain_rem_r != 8'd0) begin
            if (!ptr_vld_r || at_end_r) begin
              drain_rem_nxt = 8'd0;
            end else begin
              res_vld       = 1'b1;
              res_kind      = ptr_gfx_r ? EV_GFX_WRITE : EV_CPU_WRITE;
              res_addr      = wr_addr_r;
              res_ram       = 1'b1;
              ram_re        = 1'b1;
              at_end_nxt    = (next_addr >= (ptr_gfx_r ? GFX_LIM : CPU_LIM));
              wr_addr_nxt   = next_addr[15:0];
              drain_idx_nxt = drain_idx_r + 8'd1;
              drain_rem_nxt = drain_rem_r - 8'd1;
            end
          end
        end
        OP_RESP: begin
          if (await_r) begin
            await_nxt   = 1'b0;
            ptr_vld_nxt = 1'b1;
            ptr_gfx_nxt = 1'b0;
            wr_addr_nxt = in_read_value;
            at_end_nxt  = ({1'b0, in_read_value} >= CPU_LIM);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LENGTH;
      frame_len_r <= 8'd0;
      exp_sum_r   <= 8'd0;
      run_sum_r   <= 8'd0;
      byte_idx_r  <= 8'd0;
      ptr_vld_r   <= 1'b0;
      ptr_gfx_r   <= 1'b0;
      wr_addr_r   <= 16'd0;
      at_end_r    <= 1'b0;
      drain_rem_r <= 8'd0;
      drain_idx_r <= 8'd0;
      await_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      exp_sum_r   <= exp_sum_nxt;
      run_sum_r   <= run_sum_nxt;
      byte_idx_r  <= byte_idx_nxt;
      ptr_vld_r   <= ptr_vld_nxt;
      ptr_gfx_r   <= ptr_gfx_nxt;
      wr_addr_r   <= wr_addr_nxt;
      at_end_r    <= at_end_nxt;
      drain_rem_r <= drain_rem_nxt;
      drain_idx_r <= drain_idx_nxt;
      await_r     <= await_nxt;
      if (in_acc) begin
        p_vld_r <= res_vld;
      end else if (p_adv) begin
        p_vld_r <= 1'b0;
      end
      if (p_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head0_r <= head0_nxt;
    head1_r <= head1_nxt;
    head2_r <= head2_nxt;
    if (in_acc) begin
      p_kind_r <= res_kind;
      p_addr_r <= res_addr;
      p_data_r <= res_data;
      p_ram_r  <= res_ram;
    end
    if (p_adv) begin
      out_kind_r <= p_kind_r;
      out_addr_r <= p_addr_r;
      out_data_r <= p_ram_r ? ram_rdata : p_data_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_event_kind     = out_kind_r;
  assign out_target_address = out_addr_r;
  assign out_data_byte      = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/sufe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the serial upload frame executor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sufe_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STORE_BYTES = 256;
  localparam int         LEN_CAP     = STORE_BYTES - 2;
  localparam int         CPU_LIMIT   = 65536;
  localparam int         GFX_LIMIT   = 32768;
  localparam int         IDLE_LIMIT  = 500;
  localparam int         SETTLE_CYC  = 10;
  localparam int         ITEM_TARGET = 1450;

  typedef struct {
    ev_kind_t    kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } upload_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [15:0] in_read_value = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_kind;
  logic [15:0] out_target_address;
  logic [7:0]  out_data_byte;

  serial_upload_frame_executor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_rx_byte         (in_rx_byte),
    .in_read_value      (in_read_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_target_address (out_target_address),
    .out_data_byte      (out_data_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0]  upload_store [STORE_BYTES];
  phase_t      frame_ph = PH_LENGTH;
  logic [7:0]  frame_len = 8'd0;
  logic [7:0]  sum_due = 8'd0;
  logic [7:0]  sum_run = 8'd0;
  logic [7:0]  byte_idx = 8'd0;
  bit          ptr_ok = 1'b0;
  bit          ptr_gfx = 1'b0;
  logic [15:0] waddr = 16'h0000;
  bit          ptr_end = 1'b0;
  logic [7:0]  drain_left = 8'd0;
  logic [7:0]  drain_idx = 8'd0;
  bit          wait_ptr = 1'b0;

  upload_event_t events_due [$];
  int          errors = 0;
  int          sent_count = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  int          stall_run = 0;
  int          quiet_cycles = 0;

  function automatic void aim_pointer(input logic [15:0] addr, input bit gfx);
    ptr_ok  = 1'b1;
    ptr_gfx = gfx;
    waddr   = addr;
    ptr_end = int'(addr) >= (gfx ? GFX_LIMIT : CPU_LIMIT);
  endfunction

  function automatic bit upload_event_for(input logic [1:0] op, input logic [7:0] b,
                                          input logic [15:0] rv, output upload_event_t ev);
    logic [7:0]  cmd;
    logic [15:0] addr;
    logic [16:0] nxt;
    ev = '{kind: EV_NONE, addr: 16'h0000, data: 8'h00};
    case (op)
      OP_BYTE: begin
        if (drain_left != 8'd0 || wait_ptr) begin
          ev.kind = EV_BUSY_DROP;
          return 1'b1;
        end
        case (frame_ph)
          PH_LENGTH: begin
            if (b != 8'd0) begin
              frame_len = (int'(b) > LEN_CAP) ? 8'(LEN_CAP) : b;
              frame_ph  = PH_CHECK;
            end
            return 1'b0;
          end
          PH_CHECK: begin
            sum_due  = b;
            sum_run  = 8'd0;
            byte_idx = 8'd0;
            frame_ph = PH_PAYLOAD;
            return 1'b0;
          end
          default: begin
            upload_store[byte_idx] = b;
            sum_run  = sum_run + b;
            byte_idx = byte_idx + 8'd1;
            if (byte_idx < frame_len) return 1'b0;
            frame_ph = PH_LENGTH;
            if (sum_run != sum_due) begin
              ev.kind = EV_CSUM_ERR;
              return 1'b1;
            end
            cmd  = upload_store[0];
            addr = {upload_store[2], upload_store[1]};
            case (cmd)
              CMD_DETACH: begin
                ev.kind = EV_DETACH;
                return 1'b1;
              end
              CMD_WRITE: begin
                if (ptr_ok) begin
                  drain_left = frame_len - 8'd1;
                  drain_idx  = 8'd1;
                end
              end
              CMD_CPU_PTR: aim_pointer(addr, 1'b0);
              CMD_GFX_PTR: begin
                if (int'(addr) >= GFX_LIMIT) ptr_ok = 1'b0;
                else aim_pointer(addr, 1'b1);
              end
              CMD_IND_PTR: begin
                wait_ptr = 1'b1;
                ev.kind  = EV_PTR_READ;
                ev.addr  = addr;
                return 1'b1;
              end
              CMD_KEY: begin
                ev.kind = EV_KEY;
                ev.data = upload_store[1];
                return 1'b1;
              end
              default: ;
            endcase
            return 1'b0;
          end
        endcase
      end
      OP_TICK: begin
        if (drain_left == 8'd0) return 1'b0;
        if (!ptr_ok || ptr_end) begin
          drain_left = 8'd0;
          return 1'b0;
        end
        if (ptr_gfx) ev.kind = EV_GFX_WRITE;
        else ev.kind = EV_CPU_WRITE;
        ev.addr = waddr;
        ev.data = upload_store[drain_idx];
        nxt = {1'b0, waddr} + 17'd1;
        if (int'(nxt) >= (ptr_gfx ? GFX_LIMIT : CPU_LIMIT)) ptr_end = 1'b1;
        waddr      = nxt[15:0];
        drain_idx  = drain_idx + 8'd1;
        drain_left = drain_left - 8'd1;
        return 1'b1;
      end
      OP_RESP: begin
        if (wait_ptr) begin
          wait_ptr = 1'b0;
          aim_pointer(rv, 1'b0);
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [7:0] b, input logic [15:0] rv);
    int            gap;
    upload_event_t ev;
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 5);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_rx_byte    <= b;
    in_read_value <= rv;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (upload_event_for(op, b, rv, ev)) events_due.push_back(ev);
    sent_count++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(OP_TICK, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_command(input logic [7:0] cmd, input logic [15:0] addr,
                              input int len_byte, input bit corrupt);
    logic [7:0] body [$];
    logic [7:0] sum;
    int         n;
    n = (len_byte > LEN_CAP) ? LEN_CAP : len_byte;
    body.push_back(cmd);
    if (n > 1) body.push_back(addr[7:0]);
    if (n > 2) body.push_back(addr[15:8]);
    while (body.size() < n) body.push_back(8'($urandom));
    sum = 8'd0;
    foreach (body[i]) sum = sum + body[i];
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_req(OP_BYTE, 8'(len_byte), 16'($urandom));
    send_req(OP_BYTE, sum, 16'($urandom));
    foreach (body[i]) send_req(OP_BYTE, body[i], 16'($urandom));
  endtask

  task automatic settle_framing();
    while (wait_ptr || drain_left != 8'd0 || frame_ph != PH_LENGTH) begin
      if (wait_ptr) send_req(OP_RESP, 8'($urandom), 16'($urandom));
      else if (drain_left != 8'd0) send_req(OP_TICK, 8'($urandom), 16'($urandom));
      else send_req(OP_BYTE, 8'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h7FF0, 16'h800F));
      1: return 16'($urandom_range(16'hFFF0, 16'hFFFF));
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 99) < 2) return $urandom_range(LEN_CAP, 255);
    return $urandom_range(1, 12);
  endfunction

  task automatic test_pointer_commands();
    send_command(CMD_CPU_PTR, 16'hFFFE, 3, 1'b0);
    send_req(OP_BYTE, 8'h00, 16'h0000);
    send_command(CMD_GFX_PTR, 16'h8000, 3, 1'b0);
    send_command(CMD_WRITE, 16'($urandom), 3, 1'b0);
    send_ticks(1);
    send_command(CMD_GFX_PTR, 16'h7FFF, 3, 1'b0);
    send_command(CMD_WRITE, 16'($urandom), 3, 1'b0);
    send_ticks(3);
  endtask

  task automatic test_write_drain();
    send_command(CMD_CPU_PTR, 16'hFFFE, 3, 1'b0);
    send_command(CMD_WRITE, 16'($urandom), 5, 1'b0);
    send_req(OP_BYTE, 8'hFF, 16'hFFFF);
    send_ticks(5);
    send_command(CMD_WRITE, 16'($urandom), 1, 1'b0);
    send_ticks(1);
  endtask

  task automatic test_pointer_read();
    send_command(CMD_IND_PTR, 16'hFFFF, 3, 1'b0);
    send_req(OP_BYTE, 8'hFF, 16'h0000);
    send_ticks(1);
    send_req(OP_UNUSED, 8'hFF, 16'hFFFF);
    send_req(OP_RESP, 8'h00, 16'h0000);
    send_req(OP_RESP, 8'hFF, 16'hFFFF);
    send_command(CMD_WRITE, 16'hA55A, 3, 1'b0);
    send_ticks(2);
  endtask

  task automatic test_other_commands();
    send_command(CMD_KEY, 16'h0041, 2, 1'b0);
    send_command(CMD_DETACH, 16'h0000, 1, 1'b0);
    send_command(CMD_KEY, 16'h00FF, 3, 1'b1);
    send_command(8'hFF, 16'hFFFF, 3, 1'b0);
  endtask

  task automatic test_length_clamp();
    send_command(CMD_CPU_PTR, 16'h1000, 3, 1'b0);
    send_command(CMD_WRITE, 16'($urandom), 255, 1'b0);
    send_ticks(LEN_CAP);
  endtask

  task automatic test_random_traffic();
    int pick;
    int n;
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) sender_gaps = !sender_gaps;
      if ($urandom_range(0, 19) == 0) receiver_stalls = !receiver_stalls;
      pick = $urandom_range(0, 99);
      if (pick < 80) settle_framing();
      if (pick < 45) begin
        if ($urandom_range(0, 1) == 0) begin
          send_command($urandom_range(0, 1) ? CMD_GFX_PTR : CMD_CPU_PTR, pick_addr(),
                       $urandom_range(3, 5), 1'b0);
        end
        send_command(CMD_WRITE, 16'($urandom), pick_length(), 1'b0);
        n = int'(drain_left) + $urandom_range(0, 2);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_req(OP_BYTE, 8'($urandom), 16'($urandom));
          send_ticks(1);
        end
      end else if (pick < 60) begin
        case ($urandom_range(0, 2))
          0: send_command(CMD_CPU_PTR, pick_addr(), pick_length(), 1'b0);
          1: send_command(CMD_GFX_PTR, pick_addr(), pick_length(), 1'b0);
          default: begin
            send_command(CMD_IND_PTR, pick_addr(), pick_length(), 1'b0);
            if ($urandom_range(0, 2) == 0) send_req(OP_BYTE, 8'($urandom), 16'($urandom));
            if ($urandom_range(0, 3) == 0) send_req(OP_UNUSED, 8'($urandom), 16'($urandom));
            send_req(OP_RESP, 8'($urandom),
                     $urandom_range(0, 1) ? pick_addr() : 16'($urandom));
          end
        endcase
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0: send_command(CMD_KEY, 16'($urandom), pick_length(), 1'b0);
          1: send_command(CMD_DETACH, 16'($urandom), pick_length(), 1'b0);
          default: send_command(8'($urandom_range(6, 255)), 16'($urandom), pick_length(), 1'b0);
        endcase
      end else if (pick < 80) begin
        send_command(8'($urandom_range(0, 7)), pick_addr(), pick_length(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_req(2'($urandom_range(0, 3)),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
                   16'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!receiver_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    upload_event_t due;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (events_due.size() == 0) begin
        $error("event_kind: no event expected, got %0d", out_event_kind);
        errors++;
      end else begin
        due = events_due.pop_front();
        if (out_event_kind !== due.kind) begin
          $error("event_kind expected %0d got %0d", due.kind, out_event_kind);
          errors++;
        end
        if (out_target_address !== due.addr) begin
          $error("target_address expected %0h got %0h", due.addr, out_target_address);
          errors++;
        end
        if (out_data_byte !== due.data) begin
          $error("data_byte expected %0h got %0h", due.data, out_data_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_pointer_commands();
    test_write_drain();
    test_pointer_read();
    test_other_commands();
    test_length_clamp();
    test_random_traffic();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0 && events_due.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sufe_pkg.sv
hw/rtl/sufe_ram.sv
hw/rtl/serial_upload_frame_executor.sv
tb/sv/testbench.sv
